// ===== rtl/hot_cold_tier_migration_policy_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the tier migration policy block
// Immediate-edge and next-edge implication checks with a common report form.
// ---------------------------------------------------------------------------
`ifndef HOT_COLD_TIER_MIGRATION_POLICY_MACROS_SVH
`define HOT_COLD_TIER_MIGRATION_POLICY_MACROS_SVH

// same-edge implication, off during reset
`define HCTM_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-edge implication, off during reset
`define HCTM_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// next-edge implication, always on (reset behavior)
`define HCTM_ASSERT_RST(lbl, clk, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/hctm_pkg.sv =====
// ---------------------------------------------------------------------------
// hctm_pkg
// Shared types, codes and constants of the tier migration policy block.
// ---------------------------------------------------------------------------
package hctm_pkg;

  localparam int TAG_W   = 40;
  localparam int HEAT_W  = 16;
  localparam int NS_W    = 32;
  localparam int CNT_W   = 32;
  localparam int BUD_W   = 16;
  localparam int CFG_W   = 32;
  localparam int IDX_W   = 3;
  localparam int QDEPTH  = 2;
  localparam int QPTR_W  = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QCNT_W  = $clog2(QDEPTH + 1);

  localparam logic [HEAT_W:0] Q_ONE = 17'd32768;

  // outcome codes
  localparam logic [2:0] OC_NONE     = 3'd0;
  localparam logic [2:0] OC_MIGRATED = 3'd1;
  localparam logic [2:0] OC_LOWCONF  = 3'd2;
  localparam logic [2:0] OC_FULL     = 3'd3;
  localparam logic [2:0] OC_BUDGET   = 3'd4;
  localparam logic [2:0] OC_RECENT   = 3'd5;
  localparam logic [2:0] OC_SKIPPED  = 3'd6;
  localparam logic [2:0] OC_ACK      = 3'd7;

  // register indexes
  localparam logic [IDX_W-1:0] REG_HOT      = 3'd0;
  localparam logic [IDX_W-1:0] REG_COLD     = 3'd1;
  localparam logic [IDX_W-1:0] REG_FLOOR    = 3'd2;
  localparam logic [IDX_W-1:0] REG_RESIDE   = 3'd3;
  localparam logic [IDX_W-1:0] REG_BUDGET   = 3'd4;
  localparam logic [IDX_W-1:0] REG_FAST_CAP = 3'd5;
  localparam logic [IDX_W-1:0] REG_SLOW_CAP = 3'd6;
  localparam logic [IDX_W-1:0] REG_TELEM    = 3'd7;

  typedef enum logic [1:0] {
    OP_TICK  = 2'd0,
    OP_EVAL  = 2'd1,
    OP_PLACE = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  typedef struct packed {
    logic [HEAT_W-1:0] hot_level;
    logic [HEAT_W-1:0] cold_level;
    logic [HEAT_W-1:0] confidence_floor;
    logic [NS_W-1:0]   min_stay_ns;
    logic [BUD_W-1:0]  budget_per_cycle;
    logic [CNT_W-1:0]  fast_capacity_pages;
    logic [CNT_W-1:0]  slow_capacity_pages;
    logic              observe_only;
  } cfg_t;

  // classified word handed from front to back
  typedef struct packed {
    op_t               op;
    logic [TAG_W-1:0]  tag;
    logic              tier;
    logic              skip;
    logic              recent;
    logic              decide;
    logic              lowconf;
    logic [HEAT_W-1:0] conf;
  } qent_t;

endpackage

// ===== rtl/hot_cold_tier_migration_policy.sv =====
// ---------------------------------------------------------------------------
// hot_cold_tier_migration_policy
// Promotes hot slow-tier pages and demotes cold fast-tier pages.
//
// Input channel (in_valid/in_ready): one page word per transfer; mode selects
// a policy tick, a page evaluation, a page placement or no operation.
// Output channel (out_valid/out_ready): one result word per input word, in
// order, with the decision and the tier page counts after that word.
// Config port: cfg_we writes cfg_wdata into register cfg_index at once;
// write only while no word is in flight.
// Path: the accepted word is written into the queue, then popped into the
// output register. Throughput: one word per cycle while the receiver does not
// stall; the back end updates the page counters and budget on each pop.
// Reset: counters and budget cleared, registers to defaults, queue empty.
// Receiver stall: the output register holds its word, the two-word queue
// fills, and in_ready drops once the queue is full.
// ---------------------------------------------------------------------------
module hot_cold_tier_migration_policy import hctm_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic [IDX_W-1:0]  cfg_index,
  input  logic [CFG_W-1:0]  cfg_wdata,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [1:0]        in_mode,
  input  logic [TAG_W-1:0]  in_page_number,
  input  logic              in_tier,
  input  logic [HEAT_W-1:0] in_heat,
  input  logic              in_ever_migrated,
  input  logic [NS_W-1:0]   in_since_migration_ns,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [TAG_W-1:0]  out_page_tag,
  output logic [2:0]        out_outcome,
  output logic              out_target_tier,
  output logic [HEAT_W-1:0] out_confidence,
  output logic [CNT_W-1:0]  out_fast_used_pages,
  output logic [CNT_W-1:0]  out_slow_used_pages
);

  cfg_t  cfg_r;
  logic  q_full;
  logic  q_not_empty;
  logic  push;
  logic  pop;
  qent_t push_ent;
  qent_t head;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.hot_level           <= 16'd22938;
      cfg_r.cold_level          <= 16'd9830;
      cfg_r.confidence_floor    <= 16'd16384;
      cfg_r.min_stay_ns         <= 32'd100000000;
      cfg_r.budget_per_cycle    <= 16'd10;
      cfg_r.fast_capacity_pages <= '0;
      cfg_r.slow_capacity_pages <= '0;
      cfg_r.observe_only        <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_HOT:      cfg_r.hot_level           <= cfg_wdata[HEAT_W-1:0];
        REG_COLD:     cfg_r.cold_level          <= cfg_wdata[HEAT_W-1:0];
        REG_FLOOR:    cfg_r.confidence_floor    <= cfg_wdata[HEAT_W-1:0];
        REG_RESIDE:   cfg_r.min_stay_ns         <= cfg_wdata[NS_W-1:0];
        REG_BUDGET:   cfg_r.budget_per_cycle    <= cfg_wdata[BUD_W-1:0];
        REG_FAST_CAP: cfg_r.fast_capacity_pages <= cfg_wdata[CNT_W-1:0];
        REG_SLOW_CAP: cfg_r.slow_capacity_pages <= cfg_wdata[CNT_W-1:0];
        REG_TELEM:    cfg_r.observe_only        <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  hctm_front u_front (
    .cfg                   (cfg_r),
    .in_valid              (in_valid),
    .in_ready              (in_ready),
    .in_mode               (in_mode),
    .in_page_number        (in_page_number),
    .in_tier               (in_tier),
    .in_heat               (in_heat),
    .in_ever_migrated      (in_ever_migrated),
    .in_since_migration_ns (in_since_migration_ns),
    .q_full                (q_full),
    .push                  (push),
    .push_ent              (push_ent)
  );

  hctm_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_ent  (push_ent),
    .pop       (pop),
    .full      (q_full),
    .not_empty (q_not_empty),
    .head      (head)
  );

  hctm_back u_back (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg                 (cfg_r),
    .q_not_empty         (q_not_empty),
    .head                (head),
    .pop                 (pop),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_page_tag        (out_page_tag),
    .out_outcome         (out_outcome),
    .out_target_tier     (out_target_tier),
    .out_confidence      (out_confidence),
    .out_fast_used_pages (out_fast_used_pages),
    .out_slow_used_pages (out_slow_used_pages)
  );

endmodule

// ===== rtl/hctm_front.sv =====
// ---------------------------------------------------------------------------
// hctm_front
// Accepts page words and classifies them against the thresholds.
// ---------------------------------------------------------------------------
module hctm_front import hctm_pkg::*; (
  input  cfg_t              cfg,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [1:0]        in_mode,
  input  logic [TAG_W-1:0]  in_page_number,
  input  logic              in_tier,
  input  logic [HEAT_W-1:0] in_heat,
  input  logic              in_ever_migrated,
  input  logic [NS_W-1:0]   in_since_migration_ns,
  input  logic              q_full,
  output logic              push,
  output qent_t             push_ent
);

  logic promote;
  logic demote;
  logic [HEAT_W-1:0] conf;

  assign in_ready = !q_full;
  assign push     = in_valid && in_ready;

  assign promote = in_tier && (in_heat > cfg.hot_level);
  assign demote  = !in_tier && (in_heat < cfg.cold_level);

  always_comb begin
    conf = '0;
    if (promote) begin
      conf = in_heat;
    end else if (demote && !in_heat[HEAT_W-1]) begin
      conf = HEAT_W'(Q_ONE - {1'b0, in_heat});
    end
  end

  always_comb begin
    push_ent.op      = op_t'(in_mode);
    push_ent.tag     = in_page_number;
    push_ent.tier    = in_tier;
    push_ent.skip    = cfg.observe_only;
    push_ent.recent  = in_ever_migrated && (in_since_migration_ns < cfg.min_stay_ns);
    push_ent.decide  = promote || demote;
    push_ent.lowconf = conf < cfg.confidence_floor;
    push_ent.conf    = conf;
  end

endmodule

// ===== rtl/hctm_queue.sv =====
// ---------------------------------------------------------------------------
// hctm_queue
// Short FIFO of classified words between front and back.
// ---------------------------------------------------------------------------
module hctm_queue import hctm_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  push,
  input  qent_t push_ent,
  input  logic  pop,
  output logic  full,
  output logic  not_empty,
  output qent_t head
);

  qent_t             mem_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r;
  logic [QPTR_W-1:0] rd_ptr_r;
  logic [QCNT_W-1:0] cnt_r;
  logic [QPTR_W-1:0] wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_nxt;

  assign full      = (cnt_r == QCNT_W'(QDEPTH));
  assign not_empty = (cnt_r != '0);
  assign head      = mem_r[rd_ptr_r];

  assign wr_ptr_nxt = (wr_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_r + QPTR_W'(1);
  assign rd_ptr_nxt = (rd_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_r + QPTR_W'(1);

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_ent;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_nxt;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_nxt;
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + QCNT_W'(1);
      end else if (pop && !push) begin
        cnt_r <= cnt_r - QCNT_W'(1);
      end
    end
  end

endmodule

// ===== rtl/hctm_back.sv =====
// ---------------------------------------------------------------------------
// hctm_back
// Applies budget, capacity and counters to classified words; output register.
// ---------------------------------------------------------------------------
module hctm_back import hctm_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  cfg_t              cfg,
  input  logic              q_not_empty,
  input  qent_t             head,
  output logic              pop,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [TAG_W-1:0]  out_page_tag,
  output logic [2:0]        out_outcome,
  output logic              out_target_tier,
  output logic [HEAT_W-1:0] out_confidence,
  output logic [CNT_W-1:0]  out_fast_used_pages,
  output logic [CNT_W-1:0]  out_slow_used_pages
);

  logic [CNT_W-1:0]  fast_used_r, fast_used_nxt;
  logic [CNT_W-1:0]  slow_used_r, slow_used_nxt;
  logic [BUD_W-1:0]  cyc_mig_r, cyc_mig_nxt;
  logic              out_valid_r;
  logic [TAG_W-1:0]  tag_r;
  logic [2:0]        outcome_r, outcome_nxt;
  logic              target_r, target_nxt;
  logic [HEAT_W-1:0] conf_r, conf_nxt;
  logic [CNT_W-1:0]  dst_used;
  logic [CNT_W-1:0]  dst_cap;

  assign pop = q_not_empty && (!out_valid_r || out_ready);

  assign dst_used = head.tier ? fast_used_r : slow_used_r;
  assign dst_cap  = head.tier ? cfg.fast_capacity_pages : cfg.slow_capacity_pages;

  always_comb begin
    fast_used_nxt = fast_used_r;
    slow_used_nxt = slow_used_r;
    cyc_mig_nxt   = cyc_mig_r;
    outcome_nxt   = OC_NONE;
    target_nxt    = 1'b0;
    conf_nxt      = '0;
    unique case (head.op)
      OP_TICK: begin
        cyc_mig_nxt = '0;
        outcome_nxt = OC_ACK;
      end
      OP_PLACE: begin
        outcome_nxt = OC_ACK;
        target_nxt  = head.tier;
        if (head.tier) begin
          if (slow_used_r != '1) slow_used_nxt = slow_used_r + CNT_W'(1);
        end else begin
          if (fast_used_r != '1) fast_used_nxt = fast_used_r + CNT_W'(1);
        end
      end
      OP_EVAL: begin
        priority if (head.skip) begin
          outcome_nxt = OC_SKIPPED;
        end else if (cyc_mig_r >= cfg.budget_per_cycle) begin
          outcome_nxt = OC_BUDGET;
        end else if (head.recent) begin
          outcome_nxt = OC_RECENT;
        end else if (!head.decide) begin
          outcome_nxt = OC_NONE;
        end else begin
          target_nxt = !head.tier;
          conf_nxt   = head.conf;
          if (head.lowconf) begin
            outcome_nxt = OC_LOWCONF;
          end else if (dst_used >= dst_cap) begin
            outcome_nxt = OC_FULL;
          end else begin
            outcome_nxt = OC_MIGRATED;
            cyc_mig_nxt = cyc_mig_r + BUD_W'(1);
            if (head.tier) begin
              fast_used_nxt = fast_used_r + CNT_W'(1);
              if (slow_used_r != '0) slow_used_nxt = slow_used_r - CNT_W'(1);
            end else begin
              slow_used_nxt = slow_used_r + CNT_W'(1);
              if (fast_used_r != '0) fast_used_nxt = fast_used_r - CNT_W'(1);
            end
          end
        end
      end
      OP_NONE: begin
        outcome_nxt = OC_NONE;
      end
      default: begin
        outcome_nxt = OC_NONE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fast_used_r <= '0;
      slow_used_r <= '0;
      cyc_mig_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (pop) begin
        fast_used_r <= fast_used_nxt;
        slow_used_r <= slow_used_nxt;
        cyc_mig_r   <= cyc_mig_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      tag_r     <= head.tag;
      outcome_r <= outcome_nxt;
      target_r  <= target_nxt;
      conf_r    <= conf_nxt;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_page_tag        = tag_r;
  assign out_outcome         = outcome_r;
  assign out_target_tier     = target_r;
  assign out_confidence      = conf_r;
  assign out_fast_used_pages = fast_used_r;
  assign out_slow_used_pages = slow_used_r;

endmodule

// ===== rtl/hctm_checker.sv =====
// ---------------------------------------------------------------------------
// hctm_checker
// Port-level checks of the tier migration policy block, bound to its top.
// ---------------------------------------------------------------------------
`include "hot_cold_tier_migration_policy_macros.svh"

module hctm_checker import hctm_pkg::*; (
  input logic              clk,
  input logic              rst_n,
  input logic              out_valid,
  input logic              out_ready,
  input logic [TAG_W-1:0]  out_page_tag,
  input logic [2:0]        out_outcome,
  input logic              out_target_tier,
  input logic [HEAT_W-1:0] out_confidence,
  input logic [CNT_W-1:0]  out_fast_used_pages,
  input logic [CNT_W-1:0]  out_slow_used_pages
);

  logic [TAG_W+HEAT_W+2*CNT_W+3:0] out_word;
  logic                            stall;
  logic                            no_decision;
  logic                            no_extra;
  logic                            is_ack;

  assign out_word    = {out_page_tag, out_outcome, out_target_tier, out_confidence,
                        out_fast_used_pages, out_slow_used_pages};
  assign stall       = out_valid && !out_ready;
  assign no_decision = out_valid && (out_outcome == OC_NONE || out_outcome == OC_BUDGET ||
                                     out_outcome == OC_RECENT || out_outcome == OC_SKIPPED);
  assign no_extra    = !out_target_tier && (out_confidence == '0);
  assign is_ack      = out_valid && (out_outcome == OC_ACK);

  `HCTM_ASSERT_RST(a_rst_idle, clk, !rst_n, !out_valid, "output valid after reset")

  `HCTM_ASSERT_NXT(a_out_hold, clk, rst_n, stall, out_valid && $stable(out_word), "word changed")

  `HCTM_ASSERT_IMP(a_nodec_zero, clk, rst_n, no_decision, no_extra, "undecided word not zeroed")

  `HCTM_ASSERT_IMP(a_ack_zero, clk, rst_n, is_ack, out_confidence == '0, "ack carries confidence")

endmodule

bind hot_cold_tier_migration_policy hctm_checker u_hctm_checker (.*);
